[hw/rtl/mrfc_pkg.sv]
`timescale 1ns / 1ps

package mrfc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [7:0] OWN_ADDRESS_RESET = 8'd1;
	localparam logic [7:0] BROADCAST_ADDRESS = 8'd0;
	localparam logic [1:0] SEEN_MAX = 2'd3;

	typedef enum logic [2:0] {
		STATUS_UNICAST = 3'd0,
		STATUS_BROADCAST = 3'd1,
		STATUS_CRC_ERROR = 3'd2,
		STATUS_NOT_ADDRESSED = 3'd3,
		STATUS_SHORT = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic last_byte;
	} item_t;

	typedef struct packed {
		status_t status;
		logic [15:0] frame_crc;
		logic [15:0] computed_crc;
		logic [15:0] good_count;
		logic [15:0] error_count;
	} result_t;

	// One byte of CRC-16/Modbus, reflected, processed bit by bit.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[hw/rtl/mrfc_in_stage.sv]
`timescale 1ns / 1ps

module mrfc_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mrfc_pkg::item_t in_item,
	output logic            valid_s1,
	output mrfc_pkg::item_t item_s1,
	input  logic            taken
);

	logic accept;

	// The stage frees up in the same cycle its byte moves on.
	assign in_ready = !valid_s1 || taken;
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !taken);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

endmodule

[hw/rtl/mrfc_frame_engine.sv]
`timescale 1ns / 1ps

module mrfc_frame_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        own_address,
	input  logic              valid_s1,
	input  mrfc_pkg::item_t   item_s1,
	output logic              taken,
	output logic              out_valid,
	input  logic              out_ready,
	output mrfc_pkg::result_t result_q
);

	logic [15:0] crc_q;
	logic [15:0] tail_q;
	logic [1:0]  seen_q;
	logic [7:0]  addr_q;
	logic [15:0] good_q;
	logic [15:0] bad_q;
	logic        out_valid_q;

	logic [15:0] crc_d;
	logic [15:0] tail_d;
	logic [1:0]  seen_d;
	logic [7:0]  addr_d;
	logic [15:0] good_d;
	logic [15:0] bad_d;
	logic [15:0] fcrc;
	logic        emit;
	mrfc_pkg::result_t result_d;

	// Only a final byte needs the result register; other bytes never stall.
	assign taken = valid_s1 && (!item_s1.last_byte || !out_valid_q || out_ready);
	assign emit = taken && item_s1.last_byte;
	assign out_valid = out_valid_q;
	assign fcrc = {item_s1.data_byte, tail_q[7:0]};

	always_comb begin
		addr_d = (seen_q == 2'd0) ? item_s1.data_byte : addr_q;
		crc_d = (seen_q >= 2'd2) ? mrfc_pkg::crc_byte(crc_q, tail_q[15:8]) : crc_q;
		tail_d = {tail_q[7:0], item_s1.data_byte};
		seen_d = (seen_q == mrfc_pkg::SEEN_MAX) ? seen_q : seen_q + 2'd1;
		good_d = good_q;
		bad_d = bad_q;
		result_d.status = mrfc_pkg::STATUS_SHORT;
		result_d.frame_crc = 16'h0000;
		result_d.computed_crc = 16'h0000;
		if (seen_q >= 2'd2) begin
			result_d.frame_crc = fcrc;
			result_d.computed_crc = crc_d;
			if (fcrc != crc_d) begin
				result_d.status = mrfc_pkg::STATUS_CRC_ERROR;
				if (bad_q != mrfc_pkg::COUNT_MAX) begin
					bad_d = bad_q + 16'd1;
				end
			end else begin
				if (good_q != mrfc_pkg::COUNT_MAX) begin
					good_d = good_q + 16'd1;
				end
				if (addr_d == mrfc_pkg::BROADCAST_ADDRESS) begin
					result_d.status = mrfc_pkg::STATUS_BROADCAST;
				end else if (addr_d == own_address) begin
					result_d.status = mrfc_pkg::STATUS_UNICAST;
				end else begin
					result_d.status = mrfc_pkg::STATUS_NOT_ADDRESSED;
				end
			end
		end
		result_d.good_count = good_d;
		result_d.error_count = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= mrfc_pkg::CRC_INIT;
			tail_q <= 16'h0000;
			seen_q <= 2'd0;
			addr_q <= 8'h00;
			good_q <= 16'h0000;
			bad_q <= 16'h0000;
			out_valid_q <= 1'b0;
		end else begin
			if (taken) begin
				if (item_s1.last_byte) begin
					crc_q <= mrfc_pkg::CRC_INIT;
					tail_q <= 16'h0000;
					seen_q <= 2'd0;
					addr_q <= 8'h00;
					good_q <= good_d;
					bad_q <= bad_d;
				end else begin
					crc_q <= crc_d;
					tail_q <= tail_d;
					seen_q <= seen_d;
					addr_q <= addr_d;
				end
			end
			out_valid_q <= emit || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= result_d;
		end
	end

endmodule

[hw/rtl/modbus_rtu_frame_checker_top.sv]
`timescale 1ns / 1ps

// Modbus RTU receive frame checker. Feed the bytes of one received frame in
// order, from the address byte to the CRC high byte, one byte per input
// transaction, and raise last_byte on the CRC high byte. The block sustains
// one byte per clock cycle except while a final byte stalls: the only work
// per byte is one unrolled CRC-16 byte update between the input register and
// the result register. A result transaction follows once the final byte has
// passed the input register and the result register, carrying the status,
// the CRC found in the frame, the CRC computed over the bytes before it, and
// the saturating good and CRC-error frame counts after this frame. Frames
// shorter than three bytes report a short-frame status with both CRC fields
// zero and leave the counters alone. Intermediate bytes keep flowing while a
// finished result waits; only a final byte waits for the result register to
// drain. The own_address register is written through the configuration
// channel, resets to 1, and should be changed only while the block is idle.

module modbus_rtu_frame_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] frame_crc,
	output logic [15:0] computed_crc,
	output logic [15:0] good_count,
	output logic [15:0] error_count
);

	logic [7:0]        own_address_q;
	mrfc_pkg::item_t   in_item;
	mrfc_pkg::item_t   item_s1;
	logic              valid_s1;
	logic              taken;
	mrfc_pkg::result_t result_q;

	// Configuration writes are always taken; cfg_ready is tied high.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= mrfc_pkg::OWN_ADDRESS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			own_address_q <= cfg_data;
		end
	end

	assign in_item.data_byte = data_byte;
	assign in_item.last_byte = last_byte;

	// Input register: holds one byte so the frame state update works from a registered byte.
	mrfc_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.taken    (taken)
	);

	// Frame state, CRC update, classification, counters and the result register.
	mrfc_frame_engine u_frame_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.own_address (own_address_q),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.taken       (taken),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_q    (result_q)
	);

	assign status = result_q.status;
	assign frame_crc = result_q.frame_crc;
	assign computed_crc = result_q.computed_crc;
	assign good_count = result_q.good_count;
	assign error_count = result_q.error_count;

endmodule
